// ----- hw/rtl/priority_sorted_job_table_defines.svh -----
// Assertion macros for the priority sorted job table.
// Included by the top level; uses its clk and rst signals.
`ifndef PRIORITY_SORTED_JOB_TABLE_DEFINES_SVH
`define PRIORITY_SORTED_JOB_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSJT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSJT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/psjt_pkg.sv -----
// Shared constants, codes and control types for the priority sorted job table.
// No dependencies; the top level, datapath and controller import this package.
package psjt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CMD_W       = 2;
  localparam int ID_W        = 16;
  localparam int PRIO_W      = 16;
  localparam int STATUS_W    = 2;
  localparam int ENTRY_W     = 7;
  localparam int SLOT_W      = ID_W + PRIO_W;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic load;
    logic rm_init;
    logic rm_run;
    logic ins_init;
    logic ins_run;
  } psjt_ctrl_t;

  typedef struct packed {
    logic full;
    logic rm_done;
    logic found;
    logic ins_done;
  } psjt_stat_t;

endpackage

// ----- hw/rtl/priority_sorted_job_table.sv -----
// A refused insert or an unused command gives its result the cycle after accept.
// Insert and remove each scan the stored slots through the RAM port, one slot per cycle.
// Update runs a remove and then, if the job was found, an insert; one item is in flight at a time.
// A new item may be accepted at the edge that ends the result cycle.
// Synchronous rst clears the count and control; table contents are not cleared.
module priority_sorted_job_table (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [psjt_pkg::CMD_W-1:0]          cmd,
  input  logic [psjt_pkg::ID_W-1:0]           job_id,
  input  logic signed [psjt_pkg::PRIO_W-1:0]  new_priority,
  output logic                                done,
  output logic [psjt_pkg::STATUS_W-1:0]       status,
  output logic [psjt_pkg::ENTRY_W-1:0]        entry_count,
  output logic                                head_valid,
  output logic [psjt_pkg::ID_W-1:0]           head_job_id,
  output logic signed [psjt_pkg::PRIO_W-1:0]  head_priority
);
  import psjt_pkg::*;
`include "priority_sorted_job_table_defines.svh"

  psjt_ctrl_t ctrl;
  psjt_stat_t stat;

  psjt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .stat   (stat),
    .ctrl   (ctrl),
    .busy   (busy),
    .done   (done),
    .status (status)
  );

  psjt_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .stat          (stat),
    .job_id        (job_id),
    .new_priority  (new_priority),
    .entry_count   (entry_count),
    .head_valid    (head_valid),
    .head_job_id   (head_job_id),
    .head_priority (head_priority)
  );

  `PSJT_ASSERT_SAME(a_done_not_busy, done, !busy, "Result shown while busy.")
  `PSJT_ASSERT_NEXT(a_accept_progress, start && !busy, done || busy, "Accepted item was dropped.")
  `PSJT_ASSERT_SAME(a_full_count, done && (status == ST_FULL), stat.full, "Refused while not full.")

endmodule

// ----- hw/rtl/psjt_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module psjt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/psjt_dp.sv -----
// Datapath of the job table: slot RAM, scan pointers, count and head copy.
// Depends on psjt_pkg and psjt_ram.
module psjt_dp (
  input  logic                                    clk,
  input  logic                                    rst,
  input  psjt_pkg::psjt_ctrl_t                    ctrl,
  output psjt_pkg::psjt_stat_t                    stat,
  input  logic [psjt_pkg::ID_W-1:0]               job_id,
  input  logic signed [psjt_pkg::PRIO_W-1:0]      new_priority,
  output logic [psjt_pkg::ENTRY_W-1:0]            entry_count,
  output logic                                    head_valid,
  output logic [psjt_pkg::ID_W-1:0]               head_job_id,
  output logic signed [psjt_pkg::PRIO_W-1:0]      head_priority
);
  import psjt_pkg::*;

  logic [ID_W-1:0]          id_q;
  logic signed [PRIO_W-1:0] prio_q;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         rd_ptr;
  logic [IDX_W-1:0]         rd_idx;
  logic                     rd_vld;
  logic                     found;
  logic [ID_W-1:0]          head_id;
  logic signed [PRIO_W-1:0] head_prio;

  logic                     re;
  logic [IDX_W-1:0]         raddr;
  logic [SLOT_W-1:0]        rdata;
  logic                     we;
  logic [IDX_W-1:0]         waddr;
  logic [SLOT_W-1:0]        wdata;
  logic [ID_W-1:0]          rd_id;
  logic signed [PRIO_W-1:0] rd_prio;
  logic                     prio_less;
  logic                     rm_issue;
  logic                     ins_issue;
  logic                     rm_done;
  logic                     ins_fire;

  psjt_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    rd_id     = rdata[SLOT_W-1:PRIO_W];
    rd_prio   = rdata[PRIO_W-1:0];
    prio_less = prio_q < rd_prio;
    rm_issue  = ctrl.rm_run && (rd_ptr < count);
    ins_issue = ctrl.ins_run && (rd_ptr != '0);
    re        = rm_issue || ins_issue;
    raddr     = rm_issue ? IDX_W'(rd_ptr) : IDX_W'(rd_ptr - 1'b1);
    rm_done   = ctrl.rm_run && (rd_ptr >= count) && !rd_vld;
    ins_fire  = ctrl.ins_run && (rd_vld ? prio_less : (rd_ptr == '0));

    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    if (ctrl.rm_run && rd_vld && found) begin
      we    = 1'b1;
      waddr = rd_idx - 1'b1;
    end
    if (ctrl.ins_run && rd_vld) begin
      we    = 1'b1;
      waddr = rd_idx + 1'b1;
      if (prio_less) begin
        wdata = {id_q, prio_q};
      end
    end
    if (ctrl.ins_run && !rd_vld && (rd_ptr == '0)) begin
      we    = 1'b1;
      waddr = '0;
      wdata = {id_q, prio_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      rd_ptr <= '0;
      rd_vld <= 1'b0;
      found  <= 1'b0;
    end else begin
      if (ctrl.rm_init) begin
        rd_ptr <= '0;
        rd_vld <= 1'b0;
        found  <= 1'b0;
      end
      if (ctrl.ins_init) begin
        rd_ptr <= count;
        rd_vld <= 1'b0;
      end
      if (ctrl.rm_run) begin
        rd_vld <= rm_issue;
        if (rm_issue) begin
          rd_ptr <= rd_ptr + 1'b1;
        end
        if (rd_vld && !found && (rd_id == id_q)) begin
          found <= 1'b1;
        end
        if (rm_done && found) begin
          count <= count - 1'b1;
        end
      end
      if (ctrl.ins_run) begin
        rd_vld <= ins_issue;
        if (ins_issue) begin
          rd_ptr <= rd_ptr - 1'b1;
        end
        if (ins_fire) begin
          count <= count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      id_q   <= job_id;
      prio_q <= new_priority;
    end
    if (rm_issue) begin
      rd_idx <= IDX_W'(rd_ptr);
    end else if (ins_issue) begin
      rd_idx <= IDX_W'(rd_ptr - 1'b1);
    end
    if (we && (waddr == '0)) begin
      head_id   <= wdata[SLOT_W-1:PRIO_W];
      head_prio <= wdata[PRIO_W-1:0];
    end
  end

  always_comb begin
    stat.full     = (count == CNT_W'(TABLE_DEPTH));
    stat.rm_done  = rm_done;
    stat.found    = found;
    stat.ins_done = ins_fire;
    entry_count   = ENTRY_W'(count);
    head_valid    = (count != '0);
    head_job_id   = head_valid ? head_id : '0;
    head_priority = head_valid ? head_prio : '0;
  end

endmodule

// ----- hw/rtl/psjt_ctrl.sv -----
// Controller of the job table: sequences remove and insert scans per item.
// Depends on psjt_pkg.
module psjt_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [psjt_pkg::CMD_W-1:0]     cmd,
  input  psjt_pkg::psjt_stat_t           stat,
  output psjt_pkg::psjt_ctrl_t           ctrl,
  output logic                           busy,
  output logic                           done,
  output logic [psjt_pkg::STATUS_W-1:0]  status
);
  import psjt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RM_INIT,
    S_RM_SCAN,
    S_INS_INIT,
    S_INS_SCAN
  } state_t;

  state_t state;
  logic   upd;

  always_comb begin
    ctrl.load     = (state == S_IDLE) && start;
    ctrl.rm_init  = (state == S_RM_INIT);
    ctrl.rm_run   = (state == S_RM_SCAN);
    ctrl.ins_init = (state == S_INS_INIT);
    ctrl.ins_run  = (state == S_INS_SCAN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      upd    <= 1'b0;
      busy   <= 1'b0;
      done   <= 1'b0;
      status <= ST_DONE;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            upd <= (cmd == CMD_UPDATE);
            case (cmd)
              CMD_INSERT: begin
                if (stat.full) begin
                  done   <= 1'b1;
                  status <= ST_FULL;
                end else begin
                  busy  <= 1'b1;
                  state <= S_INS_INIT;
                end
              end
              CMD_REMOVE, CMD_UPDATE: begin
                busy  <= 1'b1;
                state <= S_RM_INIT;
              end
              default: begin
                done   <= 1'b1;
                status <= ST_DONE;
              end
            endcase
          end
        end
        S_RM_INIT: begin
          state <= S_RM_SCAN;
        end
        S_RM_SCAN: begin
          if (stat.rm_done) begin
            if (!stat.found) begin
              done   <= 1'b1;
              busy   <= 1'b0;
              status <= ST_NOT_FOUND;
              state  <= S_IDLE;
            end else if (upd) begin
              state <= S_INS_INIT;
            end else begin
              done   <= 1'b1;
              busy   <= 1'b0;
              status <= ST_DONE;
              state  <= S_IDLE;
            end
          end
        end
        S_INS_INIT: begin
          state <= S_INS_SCAN;
        end
        S_INS_SCAN: begin
          if (stat.ins_done) begin
            done   <= 1'b1;
            busy   <= 1'b0;
            status <= ST_DONE;
            state  <= S_IDLE;
          end
        end
        default: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
